// File: hw/rtl/gpioi_pkg.sv
// ----------------------------------------------------------------------------
// gpioi_pkg
// Types and constants shared by the GPIO port with interrupts.
// ----------------------------------------------------------------------------
package gpioi_pkg;

    localparam int unsigned WordWidth = 32;
    localparam int unsigned HalfPins  = 16;
    localparam int unsigned CondWidth = 2;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        REG_DATA      = 3'd0,
        REG_DIRECTION = 3'd1,
        REG_PAD       = 3'd2,
        REG_COND_LOW  = 3'd3,
        REG_COND_HIGH = 3'd4,
        REG_MASK      = 3'd5,
        REG_STATUS    = 3'd6,
        REG_ANY_EDGE  = 3'd7
    } t_reg_index;

    typedef enum logic [1:0] {
        COND_LOW  = 2'd0,
        COND_HIGH = 2'd1,
        COND_RISE = 2'd2,
        COND_FALL = 2'd3
    } t_cond;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [2:0]           reg_index;
        logic [WordWidth-1:0] write_data;
        logic [WordWidth-1:0] pad_in;
    } t_item;

    typedef struct packed {
        logic [WordWidth-1:0] read_data;
        logic [WordWidth-1:0] pad_out;
        logic [WordWidth-1:0] pad_drive_enable;
        logic                 irq_pins_low;
        logic                 irq_pins_high;
    } t_result;

endpackage

// File: hw/rtl/gpioi_if.sv
// ----------------------------------------------------------------------------
// gpioi_if
// Request and response channels of the GPIO port, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gpioi_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [2:0]  reg_index;
    logic [31:0] write_data;
    logic [31:0] pad_in;

    modport source (output valid, output opcode, output reg_index,
                    output write_data, output pad_in, input ready);
    modport sink   (input valid, input opcode, input reg_index,
                    input write_data, input pad_in, output ready);
endinterface

interface gpioi_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [31:0] pad_out;
    logic [31:0] pad_drive_enable;
    logic        irq_pins_low;
    logic        irq_pins_high;

    modport source (output valid, output read_data, output pad_out,
                    output pad_drive_enable, output irq_pins_low,
                    output irq_pins_high, input ready);
    modport sink   (input valid, input read_data, input pad_out,
                    input pad_drive_enable, input irq_pins_low,
                    input irq_pins_high, output ready);
endinterface

// File: hw/rtl/gpioi_in_stage.sv
// ----------------------------------------------------------------------------
// gpioi_in_stage
// Input register: holds one request item until the result stage can take it.
// ----------------------------------------------------------------------------
module gpioi_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gpioi_req_if.sink         i_req,
    input  logic              i_out_free,
    output logic              o_advance,
    output gpioi_pkg::t_item  o_item
);

    logic             r_valid;
    gpioi_pkg::t_item r_item;
    logic             w_take;

    assign o_advance   = r_valid && i_out_free;
    assign i_req.ready = !r_valid || o_advance;
    assign w_take      = i_req.valid && i_req.ready;
    assign o_item      = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (o_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.opcode     <= i_req.opcode;
            r_item.reg_index  <= i_req.reg_index;
            r_item.write_data <= i_req.write_data;
            r_item.pad_in     <= i_req.pad_in;
        end
    end

endmodule

// File: hw/rtl/gpioi_core.sv
// ----------------------------------------------------------------------------
// gpioi_core
// Register file, pin condition detection and result formation for one item.
// ----------------------------------------------------------------------------
module gpioi_core #(
    parameter int unsigned PIN_COUNT = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  gpioi_pkg::t_item   i_item,
    output gpioi_pkg::t_result o_result
);

    localparam int unsigned WordWidth = gpioi_pkg::WordWidth;
    localparam int unsigned CondWidth = gpioi_pkg::CondWidth;
    localparam int unsigned HalfPins  = gpioi_pkg::HalfPins;

    logic [PIN_COUNT-1:0] r_data,     n_data;
    logic [PIN_COUNT-1:0] r_dir,      n_dir;
    logic [WordWidth-1:0] r_cond_lo,  n_cond_lo;
    logic [WordWidth-1:0] r_cond_hi,  n_cond_hi;
    logic [PIN_COUNT-1:0] r_mask,     n_mask;
    logic [PIN_COUNT-1:0] r_status,   n_status;
    logic [PIN_COUNT-1:0] r_any_edge, n_any_edge;
    logic [PIN_COUNT-1:0] r_last,     n_last;

    logic [2*WordWidth-1:0] w_cond_all;
    logic [PIN_COUNT-1:0]   w_pads;
    logic [PIN_COUNT-1:0]   w_hits;
    logic [PIN_COUNT-1:0]   w_wdata;
    logic [WordWidth-1:0]   w_rdata;
    logic [WordWidth-1:0]   w_pending;

    assign w_cond_all = {r_cond_hi, r_cond_lo};
    assign w_pads     = i_item.pad_in[PIN_COUNT-1:0];
    assign w_wdata    = i_item.write_data[PIN_COUNT-1:0];

    always_comb begin
        logic [CondWidth-1:0] code;
        logic                 now_b;
        logic                 prev_b;
        logic                 hit;
        w_hits = '0;
        for (int p = 0; p < PIN_COUNT; p++) begin
            code   = w_cond_all[CondWidth*p +: CondWidth];
            now_b  = w_pads[p];
            prev_b = r_last[p];
            case (code)
                gpioi_pkg::COND_LOW:  hit = !now_b;
                gpioi_pkg::COND_HIGH: hit = now_b;
                gpioi_pkg::COND_RISE: hit = !prev_b && now_b;
                default:              hit = prev_b && !now_b;
            endcase
            if (r_any_edge[p]) begin
                hit = now_b ^ prev_b;
            end
            w_hits[p] = hit;
        end
    end

    always_comb begin
        n_data     = r_data;
        n_dir      = r_dir;
        n_cond_lo  = r_cond_lo;
        n_cond_hi  = r_cond_hi;
        n_mask     = r_mask;
        n_status   = r_status;
        n_any_edge = r_any_edge;
        n_last     = r_last;
        w_rdata    = '0;
        case (i_item.opcode)
            gpioi_pkg::OP_READ: begin
                case (i_item.reg_index)
                    gpioi_pkg::REG_DATA:
                        w_rdata = WordWidth'((r_data & r_dir) | (r_last & ~r_dir));
                    gpioi_pkg::REG_DIRECTION: w_rdata = WordWidth'(r_dir);
                    gpioi_pkg::REG_PAD:       w_rdata = WordWidth'(r_last);
                    gpioi_pkg::REG_COND_LOW:  w_rdata = r_cond_lo;
                    gpioi_pkg::REG_COND_HIGH: w_rdata = r_cond_hi;
                    gpioi_pkg::REG_MASK:      w_rdata = WordWidth'(r_mask);
                    gpioi_pkg::REG_STATUS:    w_rdata = WordWidth'(r_status);
                    default:                  w_rdata = WordWidth'(r_any_edge);
                endcase
            end
            gpioi_pkg::OP_WRITE: begin
                case (i_item.reg_index)
                    gpioi_pkg::REG_DATA:      n_data    = w_wdata;
                    gpioi_pkg::REG_DIRECTION: n_dir     = w_wdata;
                    gpioi_pkg::REG_PAD:       n_last    = r_last;
                    gpioi_pkg::REG_COND_LOW:  n_cond_lo = i_item.write_data;
                    gpioi_pkg::REG_COND_HIGH: n_cond_hi = i_item.write_data;
                    gpioi_pkg::REG_MASK:      n_mask    = w_wdata;
                    gpioi_pkg::REG_STATUS:    n_status  = r_status & ~w_wdata;
                    default:                  n_any_edge = w_wdata;
                endcase
            end
            gpioi_pkg::OP_TICK: begin
                n_status = r_status | w_hits;
                n_last   = w_pads;
            end
            default: begin
                n_last = r_last;
            end
        endcase
    end

    assign w_pending = WordWidth'(n_status & n_mask);

    assign o_result.read_data        = w_rdata;
    assign o_result.pad_out          = WordWidth'(n_data);
    assign o_result.pad_drive_enable = WordWidth'(n_dir);
    assign o_result.irq_pins_low     = |w_pending[HalfPins-1:0];
    assign o_result.irq_pins_high    = |w_pending[WordWidth-1:HalfPins];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data     <= '0;
            r_dir      <= '0;
            r_cond_lo  <= '0;
            r_cond_hi  <= '0;
            r_mask     <= '0;
            r_status   <= '0;
            r_any_edge <= '0;
            r_last     <= '0;
        end else if (i_advance) begin
            r_data     <= n_data;
            r_dir      <= n_dir;
            r_cond_lo  <= n_cond_lo;
            r_cond_hi  <= n_cond_hi;
            r_mask     <= n_mask;
            r_status   <= n_status;
            r_any_edge <= n_any_edge;
            r_last     <= n_last;
        end
    end

endmodule

// File: hw/rtl/gpioi_out_stage.sv
// ----------------------------------------------------------------------------
// gpioi_out_stage
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module gpioi_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  gpioi_pkg::t_result i_result,
    gpioi_rsp_if.source        o_rsp,
    output logic               o_free
);

    logic               r_valid;
    gpioi_pkg::t_result r_result;

    assign o_free                 = !r_valid || o_rsp.ready;
    assign o_rsp.valid            = r_valid;
    assign o_rsp.read_data        = r_result.read_data;
    assign o_rsp.pad_out          = r_result.pad_out;
    assign o_rsp.pad_drive_enable = r_result.pad_drive_enable;
    assign o_rsp.irq_pins_low     = r_result.irq_pins_low;
    assign o_rsp.irq_pins_high    = r_result.irq_pins_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_result <= i_result;
        end
    end

endmodule

// File: hw/rtl/gpio_port_with_interrupts_unit.sv
// ----------------------------------------------------------------------------
// gpio_port_with_interrupts_unit
// GPIO port of up to 32 pins with per-pin interrupt detection.
//
//   port     dir  modport  carries
//   i_req    in   sink     opcode, reg_index, write_data, pad_in
//   o_rsp    out  source   read_data, pad_out, pad_drive_enable, irq lines
//
// One item per cycle unless the result stalls: input register, then result
// register, with all pin logic in one pass between them. Synchronous reset
// clears all but the item and result data registers; no clearing pass.
// A stalled result holds; one further item waits in the input register,
// after which i_req.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module gpio_port_with_interrupts_unit #(
    parameter int unsigned PIN_COUNT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gpioi_req_if.sink   i_req,
    gpioi_rsp_if.source o_rsp
);

    logic               w_advance;
    logic               w_out_free;
    gpioi_pkg::t_item   w_item;
    gpioi_pkg::t_result w_result;

    gpioi_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_out_free (w_out_free),
        .o_advance  (w_advance),
        .o_item     (w_item)
    );

    gpioi_core #(
        .PIN_COUNT (PIN_COUNT)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (w_item),
        .o_result  (w_result)
    );

    gpioi_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_result  (w_result),
        .o_rsp     (o_rsp),
        .o_free    (w_out_free)
    );

endmodule

// File: hw/rtl/gpioi_checker.sv
// ----------------------------------------------------------------------------
// gpioi_checker
// Port-level checks on the GPIO port, bound to the top level.
// ----------------------------------------------------------------------------
module gpioi_checker #(
    parameter int unsigned PIN_COUNT = 32
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [1:0]  i_opcode,
    input logic [2:0]  i_reg_index,
    input logic [31:0] i_write_data,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_read_data,
    input logic [31:0] i_pad_out,
    input logic [31:0] i_pad_drive_enable,
    input logic        i_irq_pins_low,
    input logic        i_irq_pins_high
);

    localparam logic [31:0] PinMask = 32'((64'd1 << PIN_COUNT) - 64'd1);

    logic w_in_acc;
    logic w_out_free;

    assign w_in_acc   = i_in_valid && i_in_ready;
    assign w_out_free = !i_out_valid || i_out_ready;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_read_data)
            && $stable(i_pad_out) && $stable(i_pad_drive_enable)
            && $stable(i_irq_pins_low) && $stable(i_irq_pins_high))
        else $error("stalled result changed");

    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_opcode != gpioi_pkg::OP_READ) ##1 w_out_free
            |=> i_out_valid && i_read_data == 32'd0)
        else $error("read data not zero on a non-read item");

    a_dir_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_opcode == gpioi_pkg::OP_WRITE
            && i_reg_index == gpioi_pkg::REG_DIRECTION) ##1 w_out_free
            |=> i_out_valid && i_pad_drive_enable == ($past(i_write_data, 2) & PinMask))
        else $error("direction write not reflected on drive enable");

endmodule

bind gpio_port_with_interrupts_unit gpioi_checker #(
    .PIN_COUNT (PIN_COUNT)
) u_gpioi_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_req.valid),
    .i_in_ready         (i_req.ready),
    .i_opcode           (i_req.opcode),
    .i_reg_index        (i_req.reg_index),
    .i_write_data       (i_req.write_data),
    .i_out_valid        (o_rsp.valid),
    .i_out_ready        (o_rsp.ready),
    .i_read_data        (o_rsp.read_data),
    .i_pad_out          (o_rsp.pad_out),
    .i_pad_drive_enable (o_rsp.pad_drive_enable),
    .i_irq_pins_low     (o_rsp.irq_pins_low),
    .i_irq_pins_high    (o_rsp.irq_pins_high)
);
